@@ hdl/display_list_command_decoder_macros.svh @@
// Assertion macros for the display list command decoder checker.
// No dependencies.
`ifndef DISPLAY_LIST_COMMAND_DECODER_MACROS_SVH
`define DISPLAY_LIST_COMMAND_DECODER_MACROS_SVH
// Implication checked every clock outside reset.
`define DLCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlcd check failed");
// Next-cycle implication checked every clock outside reset.
`define DLCD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlcd check failed");
`endif

@@ hdl/dlcd_pkg.sv @@
// Shared types and constants of the display list command decoder.
// No dependencies.
package dlcd_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [0:0] CFG_LITTLE_ENDIAN = 1'd0;
  localparam logic [0:0] CFG_MAX_COMMANDS  = 1'd1;

  localparam logic [7:0] OP_MTX  = 8'h01;
  localparam logic [7:0] OP_MOVE = 8'h03;
  localparam logic [7:0] OP_VTX  = 8'h04;
  localparam logic [7:0] OP_DL   = 8'h06;
  localparam logic [7:0] OP_TIMG = 8'hfd;
  localparam logic [7:0] OP_POP  = 8'hbd;
  localparam logic [7:0] OP_TRI1 = 8'hbf;
  localparam logic [7:0] OP_TRI4 = 8'hb1;
  localparam logic [7:0] OP_END  = 8'hb8;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  kind;
    logic [23:0] cmd_offset;
    logic [31:0] raw_first;
    logic [31:0] raw_second;
    logic [2:0]  move_target;
    logic [3:0]  slot;
    logic [4:0]  item_count;
    logic [59:0] triangle_indices;
    logic [7:0]  segment;
    logic [23:0] segment_offset;
    logic        stop;
  } out_item_t;

  // Completed command handed from front to back.
  typedef struct packed {
    logic        trunc;
    logic        full;
    logic        last;
    logic [23:0] offset;
    logic [31:0] w0;
    logic [31:0] w1;
  } cmd_t;

  // byte divided by ten: reciprocal multiply, exact for 0..255
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] p;
    p = {8'd0, x} * 16'd205;
    div10 = p[15:11];
  endfunction

  // byte is a whole multiple of ten
  function automatic logic is_mult10(input logic [7:0] x);
    is_mult10 = x == ({3'd0, div10(x)} * 8'd10);
  endfunction

  function automatic logic [5:0] kind_of(input logic [7:0] op);
    case (op)
      8'h00: kind_of = 6'd1;
      8'h01: kind_of = 6'd2;
      8'h03: kind_of = 6'd3;
      8'h04: kind_of = 6'd4;
      8'h06: kind_of = 6'd5;
      8'hbf: kind_of = 6'd6;
      8'hb1: kind_of = 6'd7;
      8'hb6: kind_of = 6'd8;
      8'hb7: kind_of = 6'd9;
      8'hb8: kind_of = 6'd10;
      8'hbd: kind_of = 6'd11;
      8'hbc: kind_of = 6'd12;
      8'hbb: kind_of = 6'd13;
      8'hb9: kind_of = 6'd14;
      8'hba: kind_of = 6'd15;
      8'hc0: kind_of = 6'd16;
      8'hfd: kind_of = 6'd17;
      8'hfc: kind_of = 6'd18;
      8'hfb: kind_of = 6'd19;
      8'hfa: kind_of = 6'd20;
      8'hf9: kind_of = 6'd21;
      8'hf8: kind_of = 6'd22;
      8'hf7: kind_of = 6'd23;
      8'hf6: kind_of = 6'd24;
      8'he4: kind_of = 6'd25;
      8'he5: kind_of = 6'd25;
      8'hb4: kind_of = 6'd26;
      8'hb3: kind_of = 6'd27;
      8'hf5: kind_of = 6'd28;
      8'hf4: kind_of = 6'd29;
      8'hf3: kind_of = 6'd30;
      8'hf2: kind_of = 6'd31;
      8'hf0: kind_of = 6'd32;
      8'he7: kind_of = 6'd33;
      8'he8: kind_of = 6'd34;
      8'he6: kind_of = 6'd35;
      8'he9: kind_of = 6'd36;
      default: kind_of = 6'd0;
    endcase
  endfunction

endpackage

@@ hdl/display_list_command_decoder.sv @@
// Display list command decoder top level: front, two-entry command queue, back.
// Depends on dlcd_pkg, dlcd_front, dlcd_back.
// Throughput: one byte per cycle while the queue has room; full rises only while the queue is full.
// Latency: a result enters the queue on the cycle after the byte that completes it, and shows once at the head.
// Reset (rst, synchronous): list state and queue clear, little_endian 0,
// max_commands 65535. No clearing pass.
module display_list_command_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                push,
  output logic                full,
  input  dlcd_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output dlcd_pkg::out_item_t out_item
);
  logic           little_endian;
  logic [15:0]    max_commands;
  logic           cmd_valid;
  dlcd_pkg::cmd_t cmd;
  dlcd_pkg::cmd_t q [2];
  logic           rd, wr;
  logic [1:0]     cnt;
  logic           room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
      max_commands <= 16'hffff;
    end else if (cfg_we) begin
      if (cfg_index == dlcd_pkg::CFG_LITTLE_ENDIAN) little_endian <= cfg_data[0];
      else max_commands <= cfg_data;
    end
  end

  assign room = cnt != 2'd2;

  dlcd_front u_front (
    .clk(clk), .rst(rst), .little_endian(little_endian),
    .max_commands(max_commands), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_room(room)
  );

  // two-entry queue, head in q[0]
  assign wr = cmd_valid;
  assign rd = pop && cnt != 2'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
      if (rd) q[0] <= (wr && cnt == 2'd1) ? cmd : q[1];
      else if (wr && cnt == 2'd0) q[0] <= cmd;
      if (wr && !rd && cnt == 2'd1) q[1] <= cmd;
    end
  end
  assign empty = cnt == 2'd0;

  dlcd_back u_back (.cmd(q[0]), .res(out_item));
endmodule

@@ hdl/dlcd_front.sv @@
// Front end: collects list bytes into commands and keeps the list state.
// Depends on dlcd_pkg and dlcd_check; a local check gives bad / end for the list state.
module dlcd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               little_endian,
  input  logic [15:0]        max_commands,
  input  logic               push,
  output logic               full,
  input  dlcd_pkg::in_item_t in_item,
  output logic               cmd_valid,
  output dlcd_pkg::cmd_t     cmd,
  input  logic               cmd_room
);
  logic [2:0]  byte_position;
  logic [55:0] word_buffer;
  logic [23:0] list_offset;
  logic [15:0] commands_done;
  logic        halted;
  logic [7:0]  b [8];
  logic [31:0] w0, w1;
  logic        bad, stop_end;
  logic        produce;

  assign full = !cmd_room;

  // byte order at completion time
  always_comb begin
    for (int k = 0; k < 7; k++) b[k] = word_buffer[8*k +: 8];
    b[7] = in_item.byte_value;
    if (little_endian) begin
      w0 = {b[3], b[2], b[1], b[0]};
      w1 = {b[7], b[6], b[5], b[4]};
    end else begin
      w0 = {b[0], b[1], b[2], b[3]};
      w1 = {b[4], b[5], b[6], b[7]};
    end
  end

  // early malformed / end check feeds back into the list state
  dlcd_check u_check (.w0(w0), .w1(w1), .bad(bad), .is_end(stop_end));

  always_comb begin
    produce = 1'b0;
    cmd.trunc = 1'b0;
    cmd.full = 1'b0;
    cmd.last = in_item.last_byte;
    cmd.offset = list_offset;
    cmd.w0 = w0;
    cmd.w1 = w1;
    if (!halted) begin
      if (byte_position != 3'd7) begin
        produce = in_item.last_byte;
        cmd.trunc = 1'b1;
      end else begin
        produce = 1'b1;
        cmd.full = commands_done >= max_commands;
      end
    end
  end
  assign cmd_valid = push && cmd_room && produce;

  always_ff @(posedge clk) begin
    if (rst || (push && cmd_room && in_item.last_byte)) begin
      byte_position <= '0;
      word_buffer <= '0;
      list_offset <= '0;
      commands_done <= '0;
      halted <= 1'b0;
    end else if (push && cmd_room && !halted) begin
      if (byte_position != 3'd7) begin
        word_buffer[8*byte_position +: 8] <= in_item.byte_value;
        byte_position <= byte_position + 3'd1;
      end else begin
        byte_position <= '0;
        word_buffer <= '0;
        if (commands_done >= max_commands || bad) begin
          halted <= 1'b1;
        end else begin
          commands_done <= commands_done + 16'd1;
          list_offset <= list_offset + 24'd8;
          halted <= stop_end;
        end
      end
    end
  end
endmodule

@@ hdl/dlcd_check.sv @@
// Malformed and end-of-list test of one command, shared by front and back.
// Depends on dlcd_pkg.
module dlcd_check (
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  output logic        bad,
  output logic        is_end
);
  logic [7:0]  op, mid8, a, c, d;
  logic [15:0] lo16;
  logic [11:0] vc;
  logic        move_hit;

  always_comb begin
    op = w0[31:24];
    mid8 = w0[23:16];
    lo16 = w0[15:0];
    a = w1[23:16];
    c = w1[15:8];
    d = w1[7:0];
    vc = lo16[15:4];
    move_hit = mid8 == 8'h80 || mid8 == 8'h82 || mid8 == 8'h84 ||
               (mid8 >= 8'h86 && mid8 <= 8'h94 && !mid8[0]) ||
               mid8 == 8'h98 || mid8 == 8'h9a || mid8 == 8'h9c || mid8 == 8'h9e;
    is_end = op == dlcd_pkg::OP_END;
    case (op)
      dlcd_pkg::OP_MTX:  bad = lo16 != 16'd64;
      dlcd_pkg::OP_MOVE: bad = move_hit && lo16 != 16'd16;
      dlcd_pkg::OP_VTX:  bad = lo16 == 16'd0 || lo16[3:0] != 4'd0 || vc > 12'd16 ||
                               ({8'd0, mid8[3:0]} + vc) > 12'd16 ||
                               {4'd0, mid8[7:4]} != (vc[7:0] - 8'd1);
      dlcd_pkg::OP_DL:   bad = mid8 > 8'd1;
      dlcd_pkg::OP_POP:  bad = w1 > 32'd1;
      dlcd_pkg::OP_TRI1: bad = !dlcd_pkg::is_mult10(a) || !dlcd_pkg::is_mult10(c) ||
                               !dlcd_pkg::is_mult10(d);
      default:           bad = 1'b0;
    endcase
  end
endmodule

@@ hdl/dlcd_back.sv @@
// Back end: field decode of a queued command into a result item.
// Depends on dlcd_pkg and dlcd_check.
module dlcd_back (
  input  dlcd_pkg::cmd_t    cmd,
  output dlcd_pkg::out_item_t res
);
  logic [7:0]  op, mid8;
  logic        bad, is_end, addr;
  logic [4:0]  cnt;
  logic [59:0] tri_v;
  logic [3:0]  v0, v1, v2;

  dlcd_check u_check (.w0(cmd.w0), .w1(cmd.w1), .bad(bad), .is_end(is_end));

  always_comb begin
    op = cmd.w0[31:24];
    mid8 = cmd.w0[23:16];
    res = '0;
    res.cmd_offset = cmd.offset;
    res.stop = 1'b1;
    addr = 1'b0;
    tri_v = '0;
    cnt = '0;
    v0 = '0; v1 = '0; v2 = '0;
    if (cmd.trunc) begin
      res.status = dlcd_pkg::ST_TRUNCATED;
    end else if (cmd.full) begin
      res.status = dlcd_pkg::ST_FULL;
    end else begin
      res.status = bad ? dlcd_pkg::ST_MALFORMED : dlcd_pkg::ST_OK;
      res.kind = dlcd_pkg::kind_of(op);
      res.raw_first = cmd.w0;
      res.raw_second = cmd.w1;
      res.stop = bad || is_end || cmd.last;
      case (op)
        dlcd_pkg::OP_MTX, dlcd_pkg::OP_TIMG: addr = 1'b1;
        dlcd_pkg::OP_MOVE: begin
          addr = 1'b1;
          if (mid8 == 8'h80) res.move_target = 3'd1;
          else if (mid8 == 8'h82) res.move_target = 3'd2;
          else if (mid8 == 8'h84) res.move_target = 3'd3;
          else if (mid8 >= 8'h86 && mid8 <= 8'h94 && !mid8[0]) begin
            res.move_target = 3'd4;
            res.slot = 4'(8'(mid8 - 8'h86) >> 1);
          end else if (mid8 == 8'h98 || mid8 == 8'h9a || mid8 == 8'h9c) begin
            res.move_target = 3'd5;
            res.slot = 4'((8'(mid8 - 8'h98) >> 1) + 8'd1);
          end else if (mid8 == 8'h9e) begin
            res.move_target = 3'd5;
          end
        end
        dlcd_pkg::OP_VTX: begin
          addr = 1'b1;
          res.slot = mid8[3:0];
          res.item_count = (cmd.w0[15:4] > 12'd16) ? 5'd16 : cmd.w0[8:4];
        end
        dlcd_pkg::OP_DL: begin
          addr = 1'b1;
          res.slot = (mid8 > 8'd15) ? 4'd15 : mid8[3:0];
        end
        dlcd_pkg::OP_POP: res.slot = (cmd.w1 > 32'd15) ? 4'd15 : cmd.w1[3:0];
        dlcd_pkg::OP_TRI1: begin
          res.item_count = 5'd1;
          tri_v[4:0] = dlcd_pkg::div10(cmd.w1[23:16]);
          tri_v[9:5] = dlcd_pkg::div10(cmd.w1[15:8]);
          tri_v[14:10] = dlcd_pkg::div10(cmd.w1[7:0]);
          res.triangle_indices = tri_v;
        end
        dlcd_pkg::OP_TRI4: begin
          for (int t = 0; t < 4; t++) begin
            v0 = cmd.w1[8*t +: 4];
            v1 = cmd.w1[8*t+4 +: 4];
            v2 = cmd.w0[4*t +: 4];
            tri_v[15*t +: 15] = {1'b0, v2, 1'b0, v1, 1'b0, v0};
            if (v0 != 4'd0 || v1 != 4'd0 || v2 != 4'd0) cnt = 5'(t + 1);
          end
          res.triangle_indices = tri_v;
          res.item_count = cnt;
        end
        default: ;
      endcase
      if (addr) begin
        res.segment = cmd.w1[31:24];
        res.segment_offset = cmd.w1[23:0];
      end
    end
  end
endmodule

@@ hdl/dlcd_checker.sv @@
// Port-level checker of the display list command decoder, with its bind.
// Depends on dlcd_pkg and the macros header.
`include "display_list_command_decoder_macros.svh"
module dlcd_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input dlcd_pkg::out_item_t out_item
);
  `DLCD_ASSERT_IMP(a_trunc_stops, !empty && out_item.status == dlcd_pkg::ST_TRUNCATED, out_item.stop)
  `DLCD_ASSERT_IMP(a_full_stops, !empty && out_item.status == dlcd_pkg::ST_FULL, out_item.stop && out_item.kind == 6'd0)
  `DLCD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_item))
  `DLCD_ASSERT_NXT(a_room, full, !empty)
endmodule

bind display_list_command_decoder dlcd_checker u_dlcd_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item)
);

@@ tb/sv/display_list_command_decoder_test.sv @@
// Testbench for the display list command decoder: byte streams in, decoded commands out.
// Depends on dlcd_pkg and display_list_command_decoder; predicts every result and compares fields.
module display_list_command_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;
  logic push;
  logic full;
  dlcd_pkg::in_item_t in_item;
  logic empty;
  logic pop;
  dlcd_pkg::out_item_t out_item;

  display_list_command_decoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .in_item(in_item), .empty(empty), .pop(pop),
    .out_item(out_item)
  );

  // predictor state
  logic        le_mode;
  logic [15:0] cmd_limit;
  logic [2:0]  held_bytes;
  logic [55:0] held_buf;
  logic [23:0] list_pos;
  logic [15:0] cmds_taken;
  logic        list_stopped;

  dlcd_pkg::out_item_t decoded_q[$];
  int errors;
  int idle_cycles = 0;
  bit hold_pop;
  bit hold_start;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] join_word(logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2, logic [7:0] b3);
    if (le_mode) join_word = {b3, b2, b1, b0};
    else join_word = {b0, b1, b2, b3};
  endfunction

  function automatic logic [5:0] opcode_kind(logic [7:0] op);
    logic [5:0] k;
    case (op)
      8'h00: k = 6'd1;  8'h01: k = 6'd2;  8'h03: k = 6'd3;  8'h04: k = 6'd4;
      8'h06: k = 6'd5;  8'hbf: k = 6'd6;  8'hb1: k = 6'd7;  8'hb6: k = 6'd8;
      8'hb7: k = 6'd9;  8'hb8: k = 6'd10; 8'hbd: k = 6'd11; 8'hbc: k = 6'd12;
      8'hbb: k = 6'd13; 8'hb9: k = 6'd14; 8'hba: k = 6'd15; 8'hc0: k = 6'd16;
      8'hfd: k = 6'd17; 8'hfc: k = 6'd18; 8'hfb: k = 6'd19; 8'hfa: k = 6'd20;
      8'hf9: k = 6'd21; 8'hf8: k = 6'd22; 8'hf7: k = 6'd23; 8'hf6: k = 6'd24;
      8'he4: k = 6'd25; 8'he5: k = 6'd25; 8'hb4: k = 6'd26; 8'hb3: k = 6'd27;
      8'hf5: k = 6'd28; 8'hf4: k = 6'd29; 8'hf3: k = 6'd30; 8'hf2: k = 6'd31;
      8'hf0: k = 6'd32; 8'he7: k = 6'd33; 8'he8: k = 6'd34; 8'he6: k = 6'd35;
      8'he9: k = 6'd36;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic void clear_list_state();
    held_bytes = '0;
    held_buf = '0;
    list_pos = '0;
    cmds_taken = '0;
    list_stopped = 1'b0;
  endfunction

  // Decode one accepted byte; queue a result when one is due.
  function automatic void predict_byte(dlcd_pkg::in_item_t it);
    dlcd_pkg::out_item_t r;
    logic [7:0] b[8];
    logic [31:0] w0, w1;
    logic [7:0] op, mid8;
    logic [15:0] lo16;
    logic bad, addr;
    int c, a, cc, d;
    logic [3:0] v0, v1, v2;
    if (!list_stopped) begin
      if (held_bytes < 3'd7) begin
        if (it.last_byte) begin
          r = '0;
          r.status = dlcd_pkg::ST_TRUNCATED;
          r.cmd_offset = list_pos;
          r.stop = 1'b1;
          decoded_q.push_back(r);
        end else begin
          held_buf[8*held_bytes +: 8] = it.byte_value;
          held_bytes++;
        end
      end else begin
        r = '0;
        for (int k = 0; k < 7; k++) b[k] = held_buf[8*k +: 8];
        b[7] = it.byte_value;
        held_bytes = '0;
        held_buf = '0;
        r.cmd_offset = list_pos;
        if (cmds_taken >= cmd_limit) begin
          r.status = dlcd_pkg::ST_FULL;
          list_stopped = 1'b1;
        end else begin
          w0 = join_word(b[0], b[1], b[2], b[3]);
          w1 = join_word(b[4], b[5], b[6], b[7]);
          op = w0[31:24];
          mid8 = w0[23:16];
          lo16 = w0[15:0];
          bad = 1'b0;
          addr = 1'b0;
          r.kind = opcode_kind(op);
          r.raw_first = w0;
          r.raw_second = w1;
          case (op)
            dlcd_pkg::OP_MTX: begin
              addr = 1'b1;
              bad = lo16 != 16'd64;
            end
            dlcd_pkg::OP_MOVE: begin
              addr = 1'b1;
              if (mid8 == 8'h80) r.move_target = 3'd1;
              else if (mid8 == 8'h82) r.move_target = 3'd2;
              else if (mid8 == 8'h84) r.move_target = 3'd3;
              else if (mid8 >= 8'h86 && mid8 <= 8'h94 && !mid8[0]) begin
                r.move_target = 3'd4;
                r.slot = 4'((mid8 - 8'h86) / 2);
              end else if (mid8 == 8'h98 || mid8 == 8'h9a || mid8 == 8'h9c ||
                           mid8 == 8'h9e) begin
                r.move_target = 3'd5;
                r.slot = (mid8 == 8'h9e) ? 4'd0 : 4'((mid8 - 8'h98) / 2 + 1);
              end
              bad = r.move_target != 3'd0 && lo16 != 16'd16;
            end
            dlcd_pkg::OP_VTX: begin
              c = int'(lo16) / 16;
              addr = 1'b1;
              r.slot = mid8[3:0];
              r.item_count = c > 16 ? 5'd16 : 5'(c);
              bad = lo16 == 16'd0 || lo16[3:0] != 4'd0 || c > 16 ||
                    int'(mid8[3:0]) + c > 16 || mid8[7:4] != 4'(8'(c - 1));
              // high nibble vs an 8-bit value: nonzero upper bits mismatch
              if (8'(c - 1) > 8'hf) bad = 1'b1;
            end
            dlcd_pkg::OP_DL: begin
              addr = 1'b1;
              r.slot = mid8 > 8'd15 ? 4'd15 : mid8[3:0];
              bad = mid8 > 8'd1;
            end
            dlcd_pkg::OP_TIMG: addr = 1'b1;
            dlcd_pkg::OP_POP: begin
              r.slot = w1 > 32'd15 ? 4'd15 : w1[3:0];
              bad = w1 > 32'd1;
            end
            dlcd_pkg::OP_TRI1: begin
              a = int'(w1[23:16]); cc = int'(w1[15:8]); d = int'(w1[7:0]);
              r.item_count = 5'd1;
              r.triangle_indices[4:0] = 5'(a / 10);
              r.triangle_indices[9:5] = 5'(cc / 10);
              r.triangle_indices[14:10] = 5'(d / 10);
              bad = (a % 10) != 0 || (cc % 10) != 0 || (d % 10) != 0;
            end
            dlcd_pkg::OP_TRI4: begin
              for (int t = 0; t < 4; t++) begin
                v0 = w1[8*t +: 4];
                v1 = w1[8*t+4 +: 4];
                v2 = w0[4*t +: 4];
                r.triangle_indices[15*t +: 15] = {1'b0, v2, 1'b0, v1, 1'b0, v0};
                if (v0 != 4'd0 || v1 != 4'd0 || v2 != 4'd0) r.item_count = 5'(t + 1);
              end
            end
            default: ;
          endcase
          r.status = bad ? dlcd_pkg::ST_MALFORMED : dlcd_pkg::ST_OK;
          if (addr) begin
            r.segment = w1[31:24];
            r.segment_offset = w1[23:0];
          end
          if (bad) list_stopped = 1'b1;
          else begin
            cmds_taken++;
            list_pos = list_pos + 24'd8;
            if (op == dlcd_pkg::OP_END) list_stopped = 1'b1;
          end
        end
        r.stop = list_stopped || it.last_byte;
        decoded_q.push_back(r);
      end
    end
    if (it.last_byte) clear_list_state();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    dlcd_pkg::out_item_t w;
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0)
          report_mismatch("unexpected result", 64'(out_item.kind), 64'd0);
        else begin
          w = decoded_q.pop_front();
          if (out_item.status != w.status)
            report_mismatch("status", 64'(out_item.status), 64'(w.status));
          if (out_item.kind != w.kind)
            report_mismatch("kind", 64'(out_item.kind), 64'(w.kind));
          if (out_item.cmd_offset != w.cmd_offset)
            report_mismatch("cmd_offset", 64'(out_item.cmd_offset), 64'(w.cmd_offset));
          if (out_item.raw_first != w.raw_first)
            report_mismatch("raw_first", 64'(out_item.raw_first), 64'(w.raw_first));
          if (out_item.raw_second != w.raw_second)
            report_mismatch("raw_second", 64'(out_item.raw_second), 64'(w.raw_second));
          if (out_item.move_target != w.move_target)
            report_mismatch("move_target", 64'(out_item.move_target), 64'(w.move_target));
          if (out_item.slot != w.slot)
            report_mismatch("slot", 64'(out_item.slot), 64'(w.slot));
          if (out_item.item_count != w.item_count)
            report_mismatch("item_count", 64'(out_item.item_count), 64'(w.item_count));
          if (out_item.triangle_indices != w.triangle_indices)
            report_mismatch("triangle_indices", 64'(out_item.triangle_indices),
                            64'(w.triangle_indices));
          if (out_item.segment != w.segment)
            report_mismatch("segment", 64'(out_item.segment), 64'(w.segment));
          if (out_item.segment_offset != w.segment_offset)
            report_mismatch("segment_offset", 64'(out_item.segment_offset),
                            64'(w.segment_offset));
          if (out_item.stop != w.stop)
            report_mismatch("stop", 64'(out_item.stop), 64'(w.stop));
        end
      end
      if (hold_pop) pop <= 0;
      else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // Long receiver hold-off, counted here.
  initial begin
    wait (hold_start);
    hold_pop <= 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pop <= 0;
  end

  // Watchdog on cycles without progress.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  int burst_left;

  // Send one byte; random bursts and gaps around it.
  task automatic send_byte(logic [7:0] v, logic lst);
    dlcd_pkg::in_item_t it;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    it.byte_value = v;
    it.last_byte = lst;
    push <= 1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(it);
    burst_left--;
  endtask

  task automatic send_command(logic [31:0] w0, logic [31:0] w1, logic lst);
    logic [7:0] b[8];
    for (int k = 0; k < 4; k++) begin
      b[k]   = le_mode ? w0[8*k +: 8] : w0[8*(3-k) +: 8];
      b[k+4] = le_mode ? w1[8*k +: 8] : w1[8*(3-k) +: 8];
    end
    for (int k = 0; k < 8; k++) send_byte(b[k], lst && k == 7);
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == dlcd_pkg::CFG_LITTLE_ENDIAN) le_mode = val[0];
    else cmd_limit = val;
  endtask

  // A well-formed-ish random command word pair.
  task automatic random_command(output logic [31:0] w0, output logic [31:0] w1);
    logic [7:0] ops[14] = '{dlcd_pkg::OP_MTX, dlcd_pkg::OP_MOVE, dlcd_pkg::OP_VTX,
                            dlcd_pkg::OP_DL, dlcd_pkg::OP_TIMG, dlcd_pkg::OP_POP,
                            dlcd_pkg::OP_TRI1, dlcd_pkg::OP_TRI4, 8'h00, 8'hfc, 8'he4,
                            8'he9, 8'hb6, dlcd_pkg::OP_END};
    int c, f;
    w0 = $urandom;
    w1 = $urandom;
    if ($urandom_range(0, 9) == 0) return;
    w0[31:24] = ops[$urandom_range(0, 12)];
    if ($urandom_range(0, 40) == 0) w0[31:24] = dlcd_pkg::OP_END;
    if ($urandom_range(0, 5) == 0) return;
    case (w0[31:24])
      dlcd_pkg::OP_MTX: w0[15:0] = 16'd64;
      dlcd_pkg::OP_MOVE: begin
        w0[23:16] = 8'(8'h80 + 2 * $urandom_range(0, 15));
        w0[15:0] = 16'd16;
      end
      dlcd_pkg::OP_VTX: begin
        c = $urandom_range(1, 16);
        f = $urandom_range(0, 16 - c);
        w0[23:16] = {4'(c - 1), 4'(f)};
        w0[15:0] = 16'(16 * c);
      end
      dlcd_pkg::OP_DL: w0[23:16] = 8'($urandom_range(0, 1));
      dlcd_pkg::OP_POP: w1 = $urandom_range(0, 1);
      dlcd_pkg::OP_TRI1: w1 = {8'($urandom), 8'(10 * $urandom_range(0, 25)),
                               8'(10 * $urandom_range(0, 25)),
                               8'(10 * $urandom_range(0, 25))};
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_command({dlcd_pkg::OP_MTX, 8'h00, 16'd64}, 32'hffff_ffff, 0);
    send_command({dlcd_pkg::OP_MTX, 8'h00, 16'd63}, 32'h0, 1);
    send_command({dlcd_pkg::OP_MOVE, 8'h94, 16'd16}, 32'h0612_3456, 0);
    send_command({dlcd_pkg::OP_MOVE, 8'h9e, 16'd16}, 32'h0, 0);
    send_command({dlcd_pkg::OP_MOVE, 8'h99, 16'd3}, 32'h0, 0);
    send_command({dlcd_pkg::OP_MOVE, 8'h80, 16'd8}, 32'h0, 1);
    send_command({dlcd_pkg::OP_VTX, 8'hf0, 16'd256}, 32'h0100_0000, 0);
    send_command({dlcd_pkg::OP_VTX, 8'h11, 16'd32}, 32'h0, 1);
    send_command({dlcd_pkg::OP_VTX, 8'h00, 16'hfff0}, 32'h0, 1);
    send_command({dlcd_pkg::OP_DL, 8'h01, 16'd0}, 32'h0300_0010, 0);
    send_command({dlcd_pkg::OP_DL, 8'hff, 16'd0}, 32'h0, 1);
    send_command({dlcd_pkg::OP_POP, 24'd0}, 32'hffff_ffff, 1);
    send_command({dlcd_pkg::OP_TRI1, 24'd0}, 32'h00fa_0a14, 0);
    send_command({dlcd_pkg::OP_TRI1, 24'd0}, 32'h0001_0203, 1);
    send_command({dlcd_pkg::OP_TRI4, 24'h00_00ff}, 32'hffff_ffff, 0);
    send_command({dlcd_pkg::OP_TRI4, 24'd0}, 32'h0, 0);
    send_command({dlcd_pkg::OP_TIMG, 24'd0}, 32'hdead_beef, 0);
    send_command({8'he5, 24'h123456}, 32'h0, 0);
    send_command({8'h55, 24'h0}, 32'h0, 0);
    send_command({dlcd_pkg::OP_END, 24'h0}, 32'h0, 0);
    send_byte(8'haa, 0);
    send_byte(8'h55, 1);
    send_byte(8'h12, 0);
    send_byte(8'h34, 1);
    send_byte(8'hff, 1);
    drain();
  endtask

  task automatic random_lists(int nbytes);
    logic [31:0] w0, w1;
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        random_command(w0, w1);
        send_command(w0, w1, $urandom_range(0, 5) == 0);
        sent += 8;
      end
    end
    send_byte(8'($urandom), 1);
  endtask

  task automatic test_limits();
    write_reg(dlcd_pkg::CFG_MAX_COMMANDS, 16'd0);
    send_command({8'h00, 24'h0}, 32'h0, 0);
    send_byte(8'h0, 1);
    drain();
    write_reg(dlcd_pkg::CFG_MAX_COMMANDS, 16'd2);
    repeat (4) send_command({8'he7, 24'h0}, 32'h0, 0);
    send_byte(8'h0, 1);
    drain();
    write_reg(dlcd_pkg::CFG_MAX_COMMANDS, 16'd3);
    random_lists(150);
    drain();
    write_reg(dlcd_pkg::CFG_MAX_COMMANDS, 16'hffff);
  endtask

  // Receiver holds off long enough to fill the block, sender keeps going.
  task automatic test_backpressure();
    hold_start = 1;
    repeat (12) send_command({8'he9, 24'h0}, 32'h0, 0);
    send_byte(8'h0, 1);
    drain();
  endtask

  // Random lists in one byte order.
  task automatic test_random(logic [15:0] order);
    write_reg(dlcd_pkg::CFG_LITTLE_ENDIAN, order);
    random_lists(150);
    drain();
  endtask

  initial begin
    errors = 0;
    hold_start = 0;
    burst_left = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    push = 0;
    in_item = '0;
    le_mode = 0;
    cmd_limit = 16'hffff;
    clear_list_state();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    write_reg(dlcd_pkg::CFG_LITTLE_ENDIAN, 16'd1);
    test_directed();
    test_limits();
    test_backpressure();
    test_random(16'd0);
    test_random(16'd1);
    repeat (10) @(posedge clk);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
